// ----- hdl/lse_pkg.sv -----
// Shared types and constants for the LSB steganography embed/extract block.
// No dependencies; imported by every module of the block.
package lse_pkg;

    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 32;

    localparam logic [CfgIdxW-1:0] CFG_MODE           = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_COVER_LENGTH   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_PAYLOAD_LENGTH = 2'd2;

    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    typedef struct packed {
        logic        mode;
        logic [31:0] cover_length;
        logic [31:0] payload_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0] cover_byte;
        logic [7:0] payload_byte;
        logic       stream_start;
    } t_item;

    typedef struct packed {
        logic [7:0]  stego_byte;
        logic [7:0]  payload_out;
        logic        payload_valid;
        logic [31:0] length_out;
        logic        length_valid;
        t_status     status;
    } t_result;

endpackage

// ----- hdl/lse_cfg.sv -----
// Configuration register file: mode, cover length and payload length.
// Depends on lse_pkg.
module lse_cfg
    import lse_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    output t_cfg                o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:           r_cfg.mode           <= i_cfg_data[0];
                CFG_COVER_LENGTH:   r_cfg.cover_length   <= i_cfg_data;
                CFG_PAYLOAD_LENGTH: r_cfg.payload_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/lse_core.sv -----
// Per-byte datapath: stream counters, header/payload shifters and LSB splice.
// Depends on lse_pkg; state advances only when i_adv is high.
module lse_core
    import lse_pkg::*;
#(
    parameter int HEADER_BITS = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_result o_res
);

    localparam int          PW    = $clog2(HEADER_BITS);
    localparam logic [31:0] HB32  = 32'(HEADER_BITS);
    localparam logic [31:0] HBM1  = 32'(HEADER_BITS - 1);
    localparam logic [PW-1:0] HBM1_P = PW'(HEADER_BITS - 1);

    logic [31:0]            r_pos,  n_pos;
    logic [HEADER_BITS-1:0] r_hdr,  n_hdr;
    logic [HEADER_BITS-1:0] r_dec,  n_dec;
    logic [7:0]             r_pay,  n_pay;

    logic [31:0]            p, room, idx;
    logic [34:0]            room35, idx35, pay_bits, dec_bits;
    logic [HEADER_BITS-1:0] hdr_prev, dec_prev, hdr_new, dec_new;
    logic [7:0]             pay_prev;
    logic [PW-1:0]          hdr_sel;
    logic                   short_cover, in_cover, in_hdr, hdr_last, lsb;
    logic                   emb_active, ext_active, emb_bit;
    t_status                emb_err, ext_err;
    t_result                res;

    always_comb begin
        // A start marker clears the counters before this byte is handled
        p        = i_item.stream_start ? '0 : r_pos;
        hdr_prev = i_item.stream_start ? '0 : r_hdr;
        dec_prev = i_item.stream_start ? '0 : r_dec;
        pay_prev = i_item.stream_start ? '0 : r_pay;
        lsb      = i_item.cover_byte[0];

        short_cover = i_cfg.cover_length < HB32;
        room        = short_cover ? '0 : i_cfg.cover_length - HB32;
        room35      = 35'(room);
        in_cover    = p < i_cfg.cover_length;
        in_hdr      = p < HB32;
        hdr_last    = p == HBM1;
        idx         = p - HB32;
        idx35       = 35'(idx);
        pay_bits    = {i_cfg.payload_length, 3'b000};

        // Embed side
        emb_err    = short_cover ? ST_SHORT : ((pay_bits > room35) ? ST_OVER : ST_OK);
        hdr_sel    = HBM1_P - p[PW-1:0];
        emb_active = !in_hdr && (idx35 < pay_bits);
        emb_bit    = (idx[2:0] == 3'd0) ? i_item.payload_byte[7] : pay_prev[7];

        // Extract side
        hdr_new    = {hdr_prev[HEADER_BITS-2:0], lsb};
        dec_new    = hdr_last ? hdr_new : dec_prev;
        dec_bits   = 35'({dec_new, 3'b000});
        ext_err    = short_cover ? ST_SHORT
                   : ((p >= HBM1 && dec_bits > room35) ? ST_OVER : ST_OK);
        ext_active = !short_cover && ext_err == ST_OK && !in_hdr && in_cover
                     && (idx35 < dec_bits);

        n_pos = (p == '1) ? p : p + 32'd1;
        n_hdr = hdr_prev;
        n_dec = dec_prev;
        n_pay = pay_prev;

        res               = '0;
        res.stego_byte    = i_item.cover_byte;

        if (i_cfg.mode == MODE_EMBED) begin
            res.status = emb_err;
            if (emb_err == ST_OK && in_cover) begin
                if (in_hdr) begin
                    res.stego_byte[0] = i_cfg.payload_length[hdr_sel];
                end else if (emb_active) begin
                    res.stego_byte[0] = emb_bit;
                    n_pay = (idx[2:0] == 3'd0) ? {i_item.payload_byte[6:0], 1'b0}
                                               : {pay_prev[6:0], 1'b0};
                end
            end
        end else begin
            res.status = ext_err;
            if (!short_cover) begin
                if (in_hdr) begin
                    n_hdr = hdr_new;
                end
                n_dec            = dec_new;
                res.length_valid = hdr_last;
            end
            if (ext_active) begin
                n_pay = {pay_prev[6:0], lsb};
                if (idx[2:0] == 3'd7) begin
                    res.payload_out   = n_pay;
                    res.payload_valid = 1'b1;
                end
            end
            res.length_out = 32'(n_dec);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_hdr <= '0;
            r_dec <= '0;
            r_pay <= '0;
        end else if (i_adv) begin
            r_pos <= n_pos;
            r_hdr <= n_hdr;
            r_dec <= n_dec;
            r_pay <= n_pay;
        end
    end

    assign o_res = res;

endmodule

// ----- hdl/lsb_stego_embed_extract_top.sv -----
// LSB steganography embed/extract, top level: input and result registers.
// Depends on lse_pkg, lse_cfg and lse_core.
//
// Usage: one cover byte per transaction on the input channel (i_valid/o_stall)
// with its payload byte and a start-of-stream flag; one result per cover byte
// on the output channel (o_valid/i_stall): the stego byte, an extracted
// payload byte with its valid flag, the decoded length with its valid flag,
// and a status code. Mode, cover length and payload length are written on
// the plain register port (i_cfg_we/i_cfg_idx/i_cfg_data); the user must write
// them only while no transaction is in flight, as the block does not enforce it.
// An accepted byte waits in the input register and then moves to the result
// register; one transaction is accepted every cycle while o_stall is low. The
// stream counters and shifters advance in one step as a byte moves from the
// input register to the result register, which bounds the throughput at one
// byte per clock.
// Reset clears the configuration, counters and both valid flags; the first
// byte after reset starts a stream even without the start flag. When the
// receiver stalls, the result holds, the input register fills and o_stall
// rises until the result is taken.
module lsb_stego_embed_extract_top
    import lse_pkg::*;
#(
    parameter int HEADER_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_cover_byte,
    input  logic [7:0]          i_payload_byte,
    input  logic                i_stream_start,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_stego_byte,
    output logic [7:0]          o_payload_out,
    output logic                o_payload_valid,
    output logic [31:0]         o_length_out,
    output logic                o_length_valid,
    output logic [1:0]          o_status
);

    t_cfg    cfg;
    t_item   r_in;
    t_result r_out, res;
    logic    r_in_vld, r_out_vld;
    logic    in_acc, adv, out_take;

    lse_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lse_core #(
        .HEADER_BITS (HEADER_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cfg   (cfg),
        .i_item  (r_in),
        .o_res   (res)
    );

    // Advance when the result register is empty or being emptied
    assign out_take = r_out_vld && !i_stall;
    assign adv      = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall  = r_in_vld && !adv;
    assign in_acc   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in.cover_byte   <= i_cover_byte;
            r_in.payload_byte <= i_payload_byte;
            r_in.stream_start <= i_stream_start;
        end
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_stego_byte    = r_out.stego_byte;
    assign o_payload_out   = r_out.payload_out;
    assign o_payload_valid = r_out.payload_valid;
    assign o_length_out    = r_out.length_out;
    assign o_length_valid  = r_out.length_valid;
    assign o_status        = r_out.status;

endmodule

// ----- hdl/lse_checker.sv -----
// Port-level checker for the LSB steganography block, bound to the top level.
// Depends on lse_pkg and lsb_stego_embed_extract_top.
module lse_checker
    import lse_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_cfg_we,
    input logic [CfgIdxW-1:0]  i_cfg_idx,
    input logic [CfgDataW-1:0] i_cfg_data,
    input logic                i_valid,
    input logic                o_stall,
    input logic [7:0]          i_cover_byte,
    input logic [7:0]          i_payload_byte,
    input logic                i_stream_start,
    input logic                o_valid,
    input logic                i_stall,
    input logic [7:0]          o_stego_byte,
    input logic [7:0]          o_payload_out,
    input logic                o_payload_valid,
    input logic [31:0]         o_length_out,
    input logic                o_length_valid,
    input logic [1:0]          o_status
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_stego_byte)
                               && $stable(o_status) && $stable(o_payload_out))
        else $error("stalled result changed");

    // Header completion and payload bytes never share a transaction
    a_lv_pv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_length_valid && o_payload_valid))
        else $error("length and payload valid together");

    // A payload byte only comes out of a clean stream with a nonzero length
    a_pv_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_payload_valid |-> o_status == ST_OK && o_length_out != 32'd0)
        else $error("payload byte with error or zero length");

endmodule

bind lsb_stego_embed_extract_top lse_checker u_lse_checker (.*);
